@@ src/trpq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package trpq_pkg;

  localparam int DEF_MAX_ENTRIES = 64;
  localparam int TIME_W          = 32;
  localparam int COUNT_OUT_W     = 7;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_TICK   = 2'd1,
    MODE_TAKE   = 2'd2,
    MODE_FIND   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [15:0]       id;
    logic [7:0]        prio;
    logic [TIME_W-1:0] arrival;
  } entry_t;

  typedef struct packed {
    mode_t             mode;
    logic [15:0]       train_id;
    logic [7:0]        priority_req;
    logic [TIME_W-1:0] arr_time;
  } req_t;

  typedef struct packed {
    logic                   found;
    logic [15:0]            out_id;
    logic [7:0]             out_priority;
    logic [TIME_W-1:0]      out_arrival;
    logic                   queue_empty;
    logic [COUNT_OUT_W-1:0] pending_count;
    logic                   overflow;
  } rsp_t;

  // broadcast to every cell of the pending chain
  typedef struct packed {
    logic ins;  // open a gap at the sort position and drop the new entry in
    logic pop;  // shift the whole chain one place towards the head
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ src/trpq_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface trpq_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/trpq_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module trpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/trpq_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module trpq_cell (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire trpq_pkg::cell_ctrl_t   ctrl,
  input  wire trpq_pkg::entry_t       new_entry,
  input  wire trpq_pkg::entry_t       prev_entry,
  input  wire logic                   prev_valid,
  input  wire logic                   prev_before,
  input  wire trpq_pkg::entry_t       next_entry,
  input  wire logic                   next_valid,
  output trpq_pkg::entry_t            entry,
  output logic                        valid,
  output logic                        ahead
);
  import trpq_pkg::*;

  // held entry stays ahead of the new one (older wins full ties)
  always_comb begin
    if (entry.arrival != new_entry.arrival) begin
      ahead = valid && (entry.arrival < new_entry.arrival);
    end else begin
      ahead = valid && (entry.prio >= new_entry.prio);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.pop) begin
      valid <= next_valid;
    end else if (ctrl.ins && !ahead) begin
      valid <= prev_before ? 1'b1 : prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      entry <= next_entry;
    end else if (ctrl.ins && !ahead) begin
      entry <= prev_before ? new_entry : prev_entry;
    end
  end

endmodule

`default_nettype wire

@@ src/timed_release_priority_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Payload  Notes
// -------  ---  -------  ----------------------------------------------
// req      in   req_t    mode / train_id / priority_req / arr_time
// rsp      out  rsp_t    one response per request, held in an output reg
// cfg      in   32 bit   start_time, also loads the simulated clock
//
// Insert, tick and take: accept, then execute (insert and take in the cell chain).
// Find: accept, scan with one table read per cycle (RAM port), then execute.
// Reset (rst, synchronous) empties table and chain and sets the clock to 0.
// The next request is taken while the previous response waits in rsp; a
// stalled rsp holds the execute step until the output register frees up.

module timed_release_priority_queue #(
  parameter int MAX_ENTRIES = trpq_pkg::DEF_MAX_ENTRIES
) (
  input wire logic clk,
  input wire logic rst,
  trpq_stream_if.sink   req,
  trpq_stream_if.source rsp,
  trpq_stream_if.sink   cfg
);
  import trpq_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  state_t            state, state_next;
  req_t              req_q;
  logic [CNT_W-1:0]  entry_count, entry_count_next;
  logic [CNT_W-1:0]  pending_total, pending_next;
  logic [TIME_W-1:0] current_time, time_next;

  // find scan
  logic [IDX_W-1:0]  scan_idx;
  logic              scan_last;
  logic              scan_hit;
  logic              hit_found;
  entry_t            hit_entry;

  // table RAM
  logic              ram_we;
  logic [IDX_W-1:0]  ram_raddr;
  entry_t            ram_rdata;
  entry_t            new_entry;

  // pending chain
  cell_ctrl_t        cell_ctrl;
  entry_t            cell_entry [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] cell_valid;
  logic [MAX_ENTRIES-1:0] cell_before;

  // response
  logic              req_acc, cfg_acc;
  logic              emit_ok, emit;
  logic              head_due;
  rsp_t              res;
  logic              rsp_valid;
  rsp_t              rsp_data;

  assign req_acc   = req.valid && req.ready;
  assign cfg_acc   = cfg.valid && cfg.ready;
  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;
  assign emit_ok   = !rsp_valid || rsp.ready;

  assign new_entry.id      = req_q.train_id;
  assign new_entry.prio    = req_q.priority_req;
  assign new_entry.arrival = req_q.arr_time;

  // ---------------------------------------------------------------------
  // Entry table: slot index equals insertion order, never freed
  // ---------------------------------------------------------------------
  assign ram_raddr = (state == ST_SCAN) ? scan_idx + IDX_W'(1) : '0;
  assign scan_hit  = (ram_rdata.id == req_q.train_id);
  assign scan_last = ((CNT_W'(scan_idx) + CNT_W'(1)) == entry_count);

  trpq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (entry_count[IDX_W-1:0]),
    .wdata (new_entry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Pending list: sorted chain, head in cell 0
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    entry_t prev_e, next_e;
    logic   prev_v, prev_b, next_v;

    if (i == 0) begin : g_head
      assign prev_e = new_entry;
      assign prev_v = 1'b0;
      assign prev_b = 1'b1;
    end else begin : g_mid
      assign prev_e = cell_entry[i-1];
      assign prev_v = cell_valid[i-1];
      assign prev_b = cell_before[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign next_e = cell_entry[i];
      assign next_v = 1'b0;
    end else begin : g_body
      assign next_e = cell_entry[i+1];
      assign next_v = cell_valid[i+1];
    end

    trpq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (cell_ctrl),
      .new_entry   (new_entry),
      .prev_entry  (prev_e),
      .prev_valid  (prev_v),
      .prev_before (prev_b),
      .next_entry  (next_e),
      .next_valid  (next_v),
      .entry       (cell_entry[i]),
      .valid       (cell_valid[i]),
      .ahead       (cell_before[i])
    );
  end

  assign head_due = cell_valid[0] && (cell_entry[0].arrival <= current_time);

  // ---------------------------------------------------------------------
  // Control: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_acc) begin
          if (req.data.mode == MODE_FIND && entry_count != '0) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_EXEC;
          end
        end
      end
      ST_SCAN: begin
        if (scan_hit || scan_last) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (emit_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Control: execute step outputs
  // ---------------------------------------------------------------------
  always_comb begin
    emit             = (state == ST_EXEC) && emit_ok;
    ram_we           = 1'b0;
    cell_ctrl        = '0;
    entry_count_next = entry_count;
    pending_next     = pending_total;
    time_next        = current_time;
    res              = '0;

    if (emit) begin
      case (req_q.mode)
        MODE_INSERT: begin
          if (entry_count == CNT_W'(MAX_ENTRIES)) begin
            res.overflow = 1'b1;
          end else begin
            ram_we           = 1'b1;
            cell_ctrl.ins    = 1'b1;
            entry_count_next = entry_count + CNT_W'(1);
            pending_next     = pending_total + CNT_W'(1);
          end
        end
        MODE_TICK: begin
          time_next = current_time + TIME_W'(1);
        end
        MODE_TAKE: begin
          if (head_due) begin
            cell_ctrl.pop    = 1'b1;
            pending_next     = pending_total - CNT_W'(1);
            res.found        = 1'b1;
            res.out_id       = cell_entry[0].id;
            res.out_priority = cell_entry[0].prio;
            res.out_arrival  = cell_entry[0].arrival;
          end
        end
        MODE_FIND: begin
          if (hit_found) begin
            res.found        = 1'b1;
            res.out_id       = hit_entry.id;
            res.out_priority = hit_entry.prio;
            res.out_arrival  = hit_entry.arrival;
          end
        end
        default: ;
      endcase
    end

    res.queue_empty   = (pending_next == '0);
    res.pending_count = COUNT_OUT_W'(pending_next);
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      entry_count   <= '0;
      pending_total <= '0;
      current_time  <= '0;
      rsp_valid     <= 1'b0;
      hit_found     <= 1'b0;
    end else begin
      state         <= state_next;
      entry_count   <= entry_count_next;
      pending_total <= pending_next;
      if (cfg_acc) begin
        current_time <= TIME_W'(cfg.data);
      end else begin
        current_time <= time_next;
      end
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (req_acc) begin
        hit_found <= 1'b0;
      end else if (state == ST_SCAN && scan_hit) begin
        hit_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      req_q    <= req.data;
      scan_idx <= '0;
    end else if (state == ST_SCAN && !scan_hit && !scan_last) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
    if (state == ST_SCAN && scan_hit) begin
      hit_entry <= ram_rdata;
    end
    if (emit) begin
      rsp_data <= res;
    end
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_chain_matches_count: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(pending_total))
    else $error("pending chain occupancy differs from pending count");

  a_pending_within_table: assert property (@(posedge clk) disable iff (rst)
    pending_total <= entry_count)
    else $error("more pending entries than table entries");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    req_acc |=> state != ST_IDLE)
    else $error("request accepted but no work started");

  a_rsp_only_after_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_EXEC)
    else $error("response raised outside the execute step");

endmodule

`default_nettype wire
